### rtl/core/fhd_pkg.sv
// Shared types and constants for the frame header deframer.
`default_nettype none

package fhd_pkg;

  localparam int unsigned HEADER_BYTES = 28;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  // Header byte offsets, sized to the header byte counter
  localparam logic [4:0] OFS_VERSION  = 5'd4;
  localparam logic [4:0] OFS_KIND     = 5'd6;
  localparam logic [4:0] OFS_FLAGS    = 5'd7;
  localparam logic [4:0] OFS_ROUTE    = 5'd8;
  localparam logic [4:0] OFS_REQUEST  = 5'd12;
  localparam logic [4:0] OFS_SEQUENCE = 5'd20;
  localparam logic [4:0] OFS_LENGTH   = 5'd24;
  localparam logic [4:0] HDR_LAST     = 5'(HEADER_BYTES - 1);

  localparam logic [26:0] ABS_MAX_PAYLOAD = 27'd67108864;

  localparam logic [7:0] KIND_FIRST = 8'd1;
  localparam logic [7:0] KIND_PUSH  = 8'd3;
  localparam logic [7:0] KIND_LAST  = 8'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAGIC       = 2'd0,
    REG_VERSION     = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_MAGIC   = 4'd1,
    ST_VERSION = 4'd2,
    ST_SIZE    = 4'd3,
    ST_KIND    = 4'd4,
    ST_FLAGS   = 4'd5,
    ST_ROUTE   = 4'd6,
    ST_PUSH_ID = 4'd7,
    ST_ID_ZERO = 4'd8
  } status_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] version_word;
    logic [26:0] max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_end;
    status_t     status;
    logic [7:0]  frame_kind;
    logic [31:0] route_id;
    logic [63:0] request_number;
    logic [31:0] sequence_number;
    logic [26:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/fhd_if.sv
// Stream and result channel interfaces of the frame header deframer.
`default_nettype none

interface fhd_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface fhd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        frame_end;
  logic [3:0]  status;
  logic [7:0]  frame_kind;
  logic [31:0] route_id;
  logic [63:0] request_number;
  logic [31:0] sequence_number;
  logic [26:0] payload_length;

  modport source (
    output valid, output payload_byte, output byte_valid, output frame_end,
    output status, output frame_kind, output route_id, output request_number,
    output sequence_number, output payload_length, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_valid, input frame_end,
    input status, input frame_kind, input route_id, input request_number,
    input sequence_number, input payload_length, output ready
  );
endinterface

`default_nettype wire

### rtl/core/fhd_cfg_regs.sv
// Configuration registers of the frame header deframer.
`default_nettype none

module fhd_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [fhd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [fhd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output fhd_pkg::cfg_t                           cfg
);

  fhd_pkg::cfg_t cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.magic_word        <= '0;
      cfg_regs.version_word      <= '0;
      cfg_regs.max_payload_bytes <= fhd_pkg::ABS_MAX_PAYLOAD;
    end else if (cfg_write) begin
      case (fhd_pkg::reg_index_t'(cfg_index))
        fhd_pkg::REG_MAGIC:       cfg_regs.magic_word        <= cfg_data;
        fhd_pkg::REG_VERSION:     cfg_regs.version_word      <= cfg_data[15:0];
        fhd_pkg::REG_MAX_PAYLOAD: cfg_regs.max_payload_bytes <= cfg_data[26:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign cfg = cfg_regs;

endmodule

`default_nettype wire

### rtl/core/fhd_parser.sv
// Header parser and payload tracker: one stream byte per accepted request.
`default_nettype none

module fhd_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire fhd_pkg::cfg_t  cfg,
  input  wire logic           accept,
  input  wire logic [7:0]     stream_byte,
  output logic                res_fire,
  output fhd_pkg::result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALT    = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  header_count, header_count_next;
  logic [26:0] remaining_count, remaining_count_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [15:0] version_shift, version_shift_next;
  logic [7:0]  kind_reg, kind_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [31:0] route_reg, route_reg_next;
  logic [63:0] request_reg, request_reg_next;
  logic [31:0] sequence_reg, sequence_reg_next;
  logic [31:0] length_reg, length_reg_next;

  fhd_pkg::status_t body_status;
  fhd_pkg::status_t head_status;
  logic [26:0]      limit;

  // Body checks only read fields that are complete before the last header byte
  always_comb begin
    if (kind_reg < fhd_pkg::KIND_FIRST || kind_reg > fhd_pkg::KIND_LAST) begin
      body_status = fhd_pkg::ST_KIND;
    end else if (flags_reg != 8'd0) begin
      body_status = fhd_pkg::ST_FLAGS;
    end else if (route_reg == 32'd0) begin
      body_status = fhd_pkg::ST_ROUTE;
    end else if (kind_reg == fhd_pkg::KIND_PUSH) begin
      body_status = (request_reg != 64'd0) ? fhd_pkg::ST_PUSH_ID : fhd_pkg::ST_OK;
    end else begin
      body_status = (request_reg == 64'd0) ? fhd_pkg::ST_ID_ZERO : fhd_pkg::ST_OK;
    end
  end

  assign limit = (cfg.max_payload_bytes > fhd_pkg::ABS_MAX_PAYLOAD) ?
                 fhd_pkg::ABS_MAX_PAYLOAD : cfg.max_payload_bytes;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    remaining_count_next = remaining_count;
    magic_shift_next     = magic_shift;
    version_shift_next   = version_shift;
    kind_reg_next        = kind_reg;
    flags_reg_next       = flags_reg;
    route_reg_next       = route_reg;
    request_reg_next     = request_reg;
    sequence_reg_next    = sequence_reg;
    length_reg_next      = length_reg;
    head_status          = fhd_pkg::ST_OK;
    res_fire             = 1'b0;
    res                  = '0;

    if (accept) begin
      case (phase)
        PH_PAYLOAD: begin
          remaining_count_next = remaining_count - 27'd1;
          res_fire             = 1'b1;
          res.payload_byte     = stream_byte;
          res.byte_valid       = 1'b1;
          if (remaining_count == 27'd1) begin
            res.frame_end       = 1'b1;
            res.status          = body_status;
            res.frame_kind      = kind_reg;
            res.route_id        = route_reg;
            res.request_number  = request_reg;
            res.sequence_number = sequence_reg;
            res.payload_length  = length_reg[26:0];
            phase_next = (body_status == fhd_pkg::ST_OK) ? PH_HEADER : PH_HALT;
          end
        end
        PH_HEADER: begin
          if (header_count < fhd_pkg::OFS_VERSION) begin
            magic_shift_next = {magic_shift[23:0], stream_byte};
          end else if (header_count < fhd_pkg::OFS_KIND) begin
            version_shift_next = {version_shift[7:0], stream_byte};
          end else if (header_count == fhd_pkg::OFS_KIND) begin
            kind_reg_next = stream_byte;
          end else if (header_count == fhd_pkg::OFS_FLAGS) begin
            flags_reg_next = stream_byte;
          end else if (header_count < fhd_pkg::OFS_REQUEST) begin
            route_reg_next = {route_reg[23:0], stream_byte};
          end else if (header_count < fhd_pkg::OFS_SEQUENCE) begin
            request_reg_next = {request_reg[55:0], stream_byte};
          end else if (header_count < fhd_pkg::OFS_LENGTH) begin
            sequence_reg_next = {sequence_reg[23:0], stream_byte};
          end else begin
            length_reg_next = {length_reg[23:0], stream_byte};
          end
          header_count_next = header_count + 5'd1;

          if (header_count == fhd_pkg::HDR_LAST) begin
            header_count_next = '0;
            if (magic_shift != cfg.magic_word) begin
              head_status = fhd_pkg::ST_MAGIC;
            end else if (version_shift != cfg.version_word) begin
              head_status = fhd_pkg::ST_VERSION;
            end else if (length_reg_next > {5'd0, limit}) begin
              head_status = fhd_pkg::ST_SIZE;
            end else begin
              head_status = fhd_pkg::ST_OK;
            end

            if (head_status != fhd_pkg::ST_OK || length_reg_next == 32'd0) begin
              res_fire            = 1'b1;
              res.frame_end       = 1'b1;
              res.status          = (head_status != fhd_pkg::ST_OK) ? head_status : body_status;
              res.frame_kind      = kind_reg;
              res.route_id        = route_reg;
              res.request_number  = request_reg;
              res.sequence_number = sequence_reg;
              res.payload_length  = length_reg_next[26:0];
              phase_next = (res.status == fhd_pkg::ST_OK) ? PH_HEADER : PH_HALT;
            end else begin
              remaining_count_next = length_reg_next[26:0];
              phase_next           = PH_PAYLOAD;
            end
          end
        end
        default: begin
          // halted: drop every byte
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      remaining_count <= '0;
      magic_shift     <= '0;
      version_shift   <= '0;
      kind_reg        <= '0;
      flags_reg       <= '0;
      route_reg       <= '0;
      request_reg     <= '0;
      sequence_reg    <= '0;
      length_reg      <= '0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      remaining_count <= remaining_count_next;
      magic_shift     <= magic_shift_next;
      version_shift   <= version_shift_next;
      kind_reg        <= kind_reg_next;
      flags_reg       <= flags_reg_next;
      route_reg       <= route_reg_next;
      request_reg     <= request_reg_next;
      sequence_reg    <= sequence_reg_next;
      length_reg      <= length_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("halt phase left without reset");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining_count != 27'd0)
    else $error("payload phase with no bytes left");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= fhd_pkg::HDR_LAST)
    else $error("header byte counter out of range");

  a_mid_payload_clean: assert property (@(posedge clk) disable iff (rst)
    res_fire && !res.frame_end |-> res.status == fhd_pkg::ST_OK && res.byte_valid)
    else $error("mid-frame result carries a status");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    res_fire && res.status != fhd_pkg::ST_OK |=> phase == PH_HALT)
    else $error("error result did not halt the parser");
`endif

endmodule

`default_nettype wire

### rtl/core/fhd_result_reg.sv
// Result register between the parser and the result channel.
`default_nettype none

module fhd_result_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire fhd_pkg::result_t  res,
  output logic                   can_load,
  fhd_result_if.source           result
);

  logic             out_valid;
  fhd_pkg::result_t out_data;

  // Free when empty or when the held request leaves this cycle
  assign can_load = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.payload_byte    = out_data.payload_byte;
  assign result.byte_valid      = out_data.byte_valid;
  assign result.frame_end       = out_data.frame_end;
  assign result.status          = out_data.status;
  assign result.frame_kind      = out_data.frame_kind;
  assign result.route_id        = out_data.route_id;
  assign result.request_number  = out_data.request_number;
  assign result.sequence_number = out_data.sequence_number;
  assign result.payload_length  = out_data.payload_length;

endmodule

`default_nettype wire

### rtl/core/frame_header_deframer_top.sv
// Top level of the frame header deframer.
`default_nettype none

// Frame header deframer: takes one stream byte per request on the stream
// channel and parses a 28-byte big-endian header (magic, version, kind,
// flags, route, request id, sequence, payload length). Magic, version and
// payload size are checked on the last header byte; a failure gives one
// header-only result with frame_end set. Each payload byte then gives one
// result with byte_valid set; the last one also carries the header fields
// and the status of the kind, flags, route and request-id checks. A frame
// with zero payload length gives one header-only result at header end.
// Any error halts the block: later bytes are still taken but dropped with
// no result until reset. The parser updates its counters and
// shift registers in the cycle the byte is taken and writes any
// result straight into a single output register, so a new byte is taken
// every cycle as long as that register is empty or being drained. A stalled
// result channel holds the stream channel only while the output register
// is full. No clearing pass after reset. Write configuration only while
// idle; register 2 above 64 MiB acts as 64 MiB.
module frame_header_deframer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fhd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fhd_pkg::CFG_DATA_W-1:0]   cfg_data,
  fhd_stream_if.sink                            stream,
  fhd_result_if.source                          result
);

  fhd_pkg::cfg_t    cfg;
  fhd_pkg::result_t res;
  logic             res_fire;
  logic             can_load;
  logic             accept;

  // Hold configuration; writes land at once, there is no read-back
  fhd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Take a byte whenever the output register can absorb a result
  assign stream.ready = can_load;
  assign accept       = stream.valid && can_load;

  // Advance the header counter or payload tracker by one byte
  fhd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .stream_byte (stream.stream_byte),
    .res_fire    (res_fire),
    .res         (res)
  );

  // Hold the result until the result channel takes it
  fhd_result_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_fire),
    .res      (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

`default_nettype wire

### test/fhd_frame_checker.sv
// Frame checker: watches the deframer channels, predicts each result and compares it.
module fhd_frame_checker
  import fhd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fhd_stream_if                  stream,
  fhd_result_if                  result,
  output int unsigned            fault_count,
  output int unsigned            results_owed
);

  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_BODY,
    PARSE_HALTED
  } parse_phase_t;

  // Configuration copy
  logic [31:0] cfg_magic;
  logic [15:0] cfg_version;
  logic [26:0] cfg_max;

  // Parser copy
  parse_phase_t ph;
  logic [4:0]   hdr_cnt;
  logic [31:0]  magic_sr;
  logic [15:0]  ver_sr;
  logic [7:0]   kind_r;
  logic [7:0]   flags_r;
  logic [31:0]  route_r;
  logic [63:0]  req_r;
  logic [31:0]  seq_r;
  logic [31:0]  len_r;
  logic [26:0]  left_cnt;

  result_t owed[$];

  function automatic string describe(input result_t r);
    return $sformatf({"byte %02h bv %0d end %0d st %0d kind %02h route %08h",
                      " id %016h seq %08h len %0d"},
                     r.payload_byte, r.byte_valid, r.frame_end, r.status, r.frame_kind,
                     r.route_id, r.request_number, r.sequence_number, r.payload_length);
  endfunction

  // Body checks, in priority order: kind, flags, route, request id.
  function automatic status_t body_status();
    if (kind_r < KIND_FIRST || kind_r > KIND_LAST) return ST_KIND;
    if (flags_r != 8'h00) return ST_FLAGS;
    if (route_r == 32'h0) return ST_ROUTE;
    if (kind_r == KIND_PUSH) begin
      if (req_r != 64'h0) return ST_PUSH_ID;
    end else if (req_r == 64'h0) begin
      return ST_ID_ZERO;
    end
    return ST_OK;
  endfunction

  function automatic result_t closing(input logic [7:0] b, input logic bv, input status_t st);
    result_t r;
    r.payload_byte    = b;
    r.byte_valid      = bv;
    r.frame_end       = 1'b1;
    r.status          = st;
    r.frame_kind      = kind_r;
    r.route_id        = route_r;
    r.request_number  = req_r;
    r.sequence_number = seq_r;
    r.payload_length  = len_r[26:0];
    return r;
  endfunction

  // Append one predicted result at the back of the queue.
  task automatic enqueue_result(input result_t r);
    owed = {owed, r};
  endtask

  task automatic end_frame(input status_t st);
    hdr_cnt  = '0;
    left_cnt = '0;
    ph       = (st == ST_OK) ? PARSE_HEADER : PARSE_HALTED;
  endtask

  task automatic clear_state();
    cfg_magic   = '0;
    cfg_version = '0;
    cfg_max     = ABS_MAX_PAYLOAD;
    ph          = PARSE_HEADER;
    hdr_cnt     = '0;
    magic_sr    = '0;
    ver_sr      = '0;
    kind_r      = '0;
    flags_r     = '0;
    route_r     = '0;
    req_r       = '0;
    seq_r       = '0;
    len_r       = '0;
    left_cnt    = '0;
    owed.delete();
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [4:0]  c;
    logic [26:0] lim;
    status_t     st;
    result_t     mid;
    if (ph == PARSE_HALTED) return;
    if (ph == PARSE_BODY) begin
      if (left_cnt != '0) left_cnt--;
      if (left_cnt == '0) begin
        st = body_status();
        enqueue_result(closing(b, 1'b1, st));
        end_frame(st);
      end else begin
        mid              = '0;
        mid.payload_byte = b;
        mid.byte_valid   = 1'b1;
        mid.status       = ST_OK;
        enqueue_result(mid);
      end
      return;
    end
    c = hdr_cnt;
    if (c < OFS_VERSION) magic_sr = {magic_sr[23:0], b};
    else if (c < OFS_KIND) ver_sr = {ver_sr[7:0], b};
    else if (c == OFS_KIND) kind_r = b;
    else if (c == OFS_FLAGS) flags_r = b;
    else if (c < OFS_REQUEST) route_r = {route_r[23:0], b};
    else if (c < OFS_SEQUENCE) req_r = {req_r[55:0], b};
    else if (c < OFS_LENGTH) seq_r = {seq_r[23:0], b};
    else len_r = {len_r[23:0], b};
    hdr_cnt = c + 5'd1;
    if (c != HDR_LAST) return;
    lim = (cfg_max > ABS_MAX_PAYLOAD) ? ABS_MAX_PAYLOAD : cfg_max;
    if (magic_sr != cfg_magic) st = ST_MAGIC;
    else if (ver_sr != cfg_version) st = ST_VERSION;
    else if (len_r > {5'd0, lim}) st = ST_SIZE;
    else if (len_r == 32'h0) st = body_status();
    else begin
      hdr_cnt  = '0;
      left_cnt = len_r[26:0];
      ph       = PARSE_BODY;
      return;
    end
    enqueue_result(closing(8'h00, 1'b0, st));
    end_frame(st);
  endtask

  task automatic check_result();
    result_t seen;
    result_t want;
    logic    bad;
    seen.payload_byte    = result.payload_byte;
    seen.byte_valid      = result.byte_valid;
    seen.frame_end       = result.frame_end;
    seen.status          = status_t'(result.status);
    seen.frame_kind      = result.frame_kind;
    seen.route_id        = result.route_id;
    seen.request_number  = result.request_number;
    seen.sequence_number = result.sequence_number;
    seen.payload_length  = result.payload_length;
    if (owed.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("%0t: result with none expected: %s", $time, describe(seen));
      return;
    end
    want = owed.pop_front();
    bad = (seen.payload_byte !== want.payload_byte) || (seen.byte_valid !== want.byte_valid) ||
          (seen.frame_end !== want.frame_end) || (seen.status !== want.status) ||
          (seen.frame_kind !== want.frame_kind) || (seen.route_id !== want.route_id) ||
          (seen.request_number !== want.request_number) ||
          (seen.sequence_number !== want.sequence_number) ||
          (seen.payload_length !== want.payload_length);
    if (bad) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: result mismatch, expected %s", $time, describe(want));
        $display("%0t:                  got      %s", $time, describe(seen));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_MAGIC:       cfg_magic = cfg_data;
          REG_VERSION:     cfg_version = cfg_data[15:0];
          REG_MAX_PAYLOAD: cfg_max = cfg_data[26:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) check_result();
      if (stream.valid && stream.ready) parse_byte(stream.stream_byte);
    end
    results_owed = owed.size();
  end

endmodule

### test/tb_frame_header_deframer_top.sv
// Testbench top for the frame header deframer: stimulus, handshake pacing and verdict.
module tb_frame_header_deframer_top;
  import fhd_pkg::*;

  // Generous ceiling: about 2500 bytes, each one waiting out a sender gap and
  // a receiver stall, plus the long hold-off and the settling pauses.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PHASE_BYTES = 500;
  localparam int unsigned NOISE_BYTES = 60;
  localparam int unsigned BODY_CAP    = 48;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned fault_count;
  int unsigned results_owed;

  // Pacing controls shared between the stimulus and the result drain, and the count of bytes fed
  bit          idle_on;
  bit          hold_req;
  int unsigned bytes_fed;

  // What the stimulus believes the block is configured to
  logic [31:0] want_magic;
  logic [15:0] want_version;
  int unsigned size_cap;

  fhd_stream_if stream_ch ();
  fhd_result_if result_ch ();

  frame_header_deframer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stream    (stream_ch),
    .result    (result_ch)
  );

  fhd_frame_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream       (stream_ch),
    .result       (result_ch),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one byte as a request and hold it until the block takes it. Every
  // call starts and ends on a falling edge, so valid is written once per step.
  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      stream_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    do @(posedge clk); while (!stream_ch.ready);
    bytes_fed++;
    @(negedge clk);
  endtask

  // Lay the header out big-endian, byte 0 first, then the body bytes.
  task automatic send_frame(input logic [31:0] mg, input logic [15:0] vr,
                            input logic [7:0] kd, input logic [7:0] fl,
                            input logic [31:0] rt, input logic [63:0] id,
                            input logic [31:0] sq, input logic [31:0] len,
                            input int unsigned n_body);
    logic [223:0] hdr;
    hdr = {mg, vr, kd, fl, rt, id, sq, len};
    for (int i = 27; i >= 0; i--) push_byte(hdr[i*8 +: 8]);
    for (int unsigned i = 0; i < n_body; i++) push_byte(8'($urandom));
  endtask

  // Drop valid and wait until every predicted result has drained, then let
  // the block settle before touching its registers.
  task automatic drain_wait();
    stream_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] mg, input logic [15:0] vr,
                            input logic [26:0] mx);
    write_reg(REG_MAGIC, mg);
    write_reg(REG_VERSION, 32'(vr));
    write_reg(REG_MAX_PAYLOAD, 32'(mx));
    cfg_write    <= 1'b0;
    want_magic   = mg;
    want_version = vr;
    size_cap     = (mx > ABS_MAX_PAYLOAD) ? ABS_MAX_PAYLOAD : mx;
  endtask

  // Keep bodies short; now and then land exactly on the body cap or the size limit, whichever is lower.
  function automatic logic [31:0] pick_len();
    int unsigned top_len;
    top_len = (size_cap < BODY_CAP) ? size_cap : BODY_CAP;
    if ($urandom_range(0, 7) == 0) return top_len;
    return $urandom_range(0, top_len);
  endfunction

  // Well-formed frame with random header content and body.
  task automatic send_good_frame(input logic [31:0] len);
    logic [7:0]  kd;
    logic [31:0] rt;
    logic [63:0] id;
    kd = 8'($urandom_range(KIND_FIRST, KIND_LAST));
    rt = $urandom;
    if (rt == 32'h0) rt = 32'h1;
    id = {$urandom, $urandom};
    if (id == 64'h0) id = 64'h1;
    if (kd == KIND_PUSH) id = '0;
    send_frame(want_magic, want_version, kd, 8'h00, rt, id, $urandom, len, len);
  endtask

  // One broken frame of a randomly chosen kind. Lower-priority faults are
  // mixed in at random so the check order is exercised. Header faults halt
  // the block at once, so no body follows them.
  task automatic send_broken_frame();
    status_t     err;
    logic [31:0] mg;
    logic [15:0] vr;
    logic [7:0]  kd;
    logic [7:0]  fl;
    logic [31:0] rt;
    logic [63:0] id;
    logic [31:0] len;
    int unsigned n_body;
    err = status_t'($urandom_range(ST_MAGIC, ST_ID_ZERO));
    mg  = want_magic;
    vr  = want_version;
    kd  = 8'($urandom_range(KIND_FIRST, KIND_LAST));
    fl  = 8'h00;
    rt  = $urandom | 32'h1;
    id  = (kd == KIND_PUSH) ? 64'h0 : {$urandom, $urandom | 32'h1};
    len = pick_len();
    case (err)
      ST_MAGIC: begin
        mg = mg ^ (32'h1 << $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) vr = ~vr;
        if ($urandom_range(0, 1) == 1) len = 32'hFFFF_FFFF;
      end
      ST_VERSION: begin
        vr = vr ^ (16'h1 << $urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) len = 32'hFFFF_FFFF;
      end
      ST_SIZE: begin
        len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : size_cap + 1;
        if ($urandom_range(0, 1) == 1) kd = 8'h00;
      end
      ST_KIND: begin
        kd = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(KIND_LAST + 1, 255));
        fl = 8'($urandom);
      end
      ST_FLAGS: begin
        fl = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) rt = 32'h0;
      end
      ST_ROUTE: begin
        rt = 32'h0;
        if ($urandom_range(0, 1) == 1) id = ~id;
      end
      ST_PUSH_ID: begin
        kd = KIND_PUSH;
        id = {$urandom, $urandom | 32'h1};
      end
      default: begin
        // request id of zero on a kind other than push
        kd = 8'($urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 1) == 0 ? 2 : 4));
        id = 64'h0;
      end
    endcase
    n_body = (err == ST_MAGIC || err == ST_VERSION || err == ST_SIZE) ? 0 : len;
    send_frame(mg, vr, kd, fl, rt, id, $urandom, len, n_body);
  endtask

  // Result drain: random stall bursts while pacing is on, plus one long
  // counted hold-off on request so the output register fills and the block
  // has to stall its stream input.
  initial begin : result_drain
    int unsigned burst;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        burst = $urandom_range(1, 6);
        repeat (burst - 1) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run as a failure if the traffic locks up.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_frame_header_deframer_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start;
    logic [26:0] mx;
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = REG_MAGIC;
    cfg_data              = '0;
    stream_ch.valid       = 1'b0;
    stream_ch.stream_byte = 8'h00;
    idle_on               = 1'b1;
    hold_req              = 1'b0;
    bytes_fed             = 0;
    want_magic            = '0;
    want_version          = '0;
    size_cap              = ABS_MAX_PAYLOAD;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: all-ones magic, zero version, limit above the 64 MiB ceiling.
    // Cover each valid kind, field extremes and an empty frame.
    set_config(32'hFFFF_FFFF, 16'h0000, 27'h7FF_FFFF);
    send_frame(want_magic, want_version, 8'd1, 8'h00, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               32'h0, 32'd0, 0);
    send_frame(want_magic, want_version, 8'd4, 8'h00, 32'h1, 64'h1, 32'hFFFF_FFFF, 32'd1, 1);
    send_frame(want_magic, want_version, KIND_PUSH, 8'h00, 32'h8000_0000, 64'h0,
               32'h1234_5678, 32'd2, 2);
    send_frame(want_magic, want_version, 8'd2, 8'h00, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000,
               $urandom, 32'd3, 3);
    drain_wait();

    // Zero limit: only empty frames get through.
    set_config(32'h0000_0000, 16'hFFFF, 27'd0);
    send_frame(want_magic, want_version, KIND_PUSH, 8'h00, 32'h5A5A_A5A5, 64'h0,
               $urandom, 32'd0, 0);
    send_frame(want_magic, want_version, 8'd2, 8'h00, $urandom | 32'h1,
               {$urandom, $urandom | 32'h1}, $urandom, 32'd0, 0);
    drain_wait();

    // Limit of one: a one-byte body sits exactly on the limit.
    set_config(32'hA5A5_5A5A, 16'h8001, 27'd1);
    send_frame(want_magic, want_version, 8'd1, 8'h00, 32'h1, 64'h2, $urandom, 32'd1, 1);
    send_frame(want_magic, want_version, 8'd4, 8'h00, 32'h3, 64'h4, $urandom, 32'd0, 0);
    drain_wait();

    // Random phases of well-formed frames, each under a fresh configuration:
    // limit above the ceiling, at the ceiling, then small limits. The last
    // phase runs with no pacing gaps and ends on one broken frame.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: mx = 27'h7FF_FFFF;
        1: mx = ABS_MAX_PAYLOAD;
        default: mx = 27'($urandom_range(1, BODY_CAP));
      endcase
      if (p == 3) idle_on = 1'b0;
      set_config($urandom, 16'($urandom), mx);
      if (p == 0) begin
        // hold the result side off while a long frame keeps coming
        hold_req = 1'b1;
        send_good_frame(BODY_CAP);
      end
      phase_start = bytes_fed;
      while (bytes_fed - phase_start < PHASE_BYTES) send_good_frame(pick_len());
      if (p < 3) drain_wait();
    end

    // Any error halts the block for good, so it comes last; the trailing
    // noise must all be dropped without a result.
    send_broken_frame();
    for (int unsigned i = 0; i < NOISE_BYTES; i++) push_byte(8'($urandom));
    drain_wait();
    repeat (8) @(negedge clk);

    if (fault_count == 0) begin
      $display("tb_frame_header_deframer_top: done, clean");
    end else begin
      $display("tb_frame_header_deframer_top: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fhd_pkg.sv
rtl/core/fhd_if.sv
rtl/core/fhd_cfg_regs.sv
rtl/core/fhd_parser.sv
rtl/core/fhd_result_reg.sv
rtl/core/frame_header_deframer_top.sv
test/fhd_frame_checker.sv
test/tb_frame_header_deframer_top.sv
